// File: src/oli_pkg.sv
// Shared constants, codes and types of the ordered list block.
package oli_pkg;

  // Store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DUMPED    = 3'd5;

  // One result word from the list engine to the output stage
  typedef struct packed {
    logic              valid;
    logic [2:0]        status;
    logic [VAL_W-1:0]  value;
    logic              last;
  } oli_res_t;

endpackage

// File: src/oli_core.sv
// List engine: entry memory, single key comparator and the request sequencer.
module oli_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic signed [oli_pkg::VAL_W-1:0] in_value,
  output oli_pkg::oli_res_t           res,
  input  logic                        res_ready
);
  import oli_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EMIT      = 3'd1;
  localparam logic [2:0] S_SCAN_RD   = 3'd2;
  localparam logic [2:0] S_SCAN_CMP  = 3'd3;
  localparam logic [2:0] S_SHIFT_RD  = 3'd4;
  localparam logic [2:0] S_SHIFT_WR  = 3'd5;
  localparam logic [2:0] S_DUMP_RD   = 3'd6;
  localparam logic [2:0] S_DUMP_EMIT = 3'd7;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [VAL_W-1:0] key, key_next;
  logic [2:0]       res_status, res_status_next;
  logic [VAL_W-1:0] res_value, res_value_next;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic [CNT_W-1:0] idx_plus1;
  logic             idx_is_tail;
  logic             key_match;
  logic             accept;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == S_IDLE);
  assign idx_plus1   = CNT_W'(idx) + CNT_W'(1);
  assign idx_is_tail = (idx_plus1 == count);
  assign key_match   = (rd_data == key);

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    key_next        = key;
    res_status_next = res_status;
    res_value_next  = res_value;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;
    res.valid       = 1'b0;
    res.status      = res_status;
    res.value       = res_value;
    res.last        = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          key_next       = in_value;
          res_value_next = in_value;
          idx_next       = '0;
          case (in_mode)
            MODE_INSERT: begin
              if (count >= CAP_C) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_addr         = count[IDX_W-1:0];
                wr_data         = in_value;
                count_next      = count + CNT_W'(1);
                res_status_next = ST_INSERTED;
              end
              state_next = S_EMIT;
            end
            MODE_DELETE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            MODE_DUMP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                res_value_next  = '0;
                state_next      = S_EMIT;
              end else begin
                state_next = S_DUMP_RD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // Compare the fetched entry against the key
        if (key_match) begin
          state_next = S_SHIFT_RD;
        end else if (idx_is_tail) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_EMIT;
        end else begin
          idx_next   = idx_plus1[IDX_W-1:0];
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        // Close up the gap one entry at a time
        if (idx_is_tail) begin
          count_next      = count - CNT_W'(1);
          res_status_next = ST_DELETED;
          state_next      = S_EMIT;
        end else begin
          rd_addr    = idx_plus1[IDX_W-1:0];
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rd_data;
        idx_next   = idx_plus1[IDX_W-1:0];
        state_next = S_SHIFT_RD;
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        res.valid  = 1'b1;
        res.status = ST_DUMPED;
        res.value  = rd_data;
        res.last   = idx_is_tail;
        if (res_ready) begin
          if (idx_is_tail) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_plus1[IDX_W-1:0];
            state_next = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && in_mode == MODE_INSERT && count < CAP_C |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res_ready |=> res.valid && $stable(res.value) && $stable(res.status))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && res.valid))
    else $error("request taken while a result is pending");

endmodule

// File: src/ordered_list_insert_delete.sv
// Top level of the ordered list: stream ports and the output register stage.
//
// Bounded list of signed 32-bit values kept in insertion order.
// Slave channel s_axis: one word per request, tuser = mode (insert, delete
// first match, dump), tdata = value or key. Master channel m_axis: result
// words, tuser = status, tdata = entry value or key, tlast marks the last
// result of a request.
// One request is handled at a time; s_axis_tready is high only while the
// engine is idle. Insert: result goes via the emit state to the output
// register. Delete: the single memory read port is shared by the key scan
// and close-up shift; each scanned entry takes a read and a compare step,
// each moved entry a read and a write step. Dump: one word per entry read.
// An empty list or a full insert answers with one word. Results pass
// through a one-word output register; while it is full and m_axis_tready
// is low the engine holds its pending result and takes no new request.
// Reset (rst, synchronous) empties the list and drops any pending result.
module ordered_list_insert_delete (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] entry_value
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast    // final_res
);
  import oli_pkg::*;

  oli_res_t         res;
  logic             res_ready;
  logic             out_valid;
  logic [2:0]       out_status;
  logic [VAL_W-1:0] out_value;
  logic             out_last;

  oli_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .res       (res),
    .res_ready (res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status <= res.status;
      out_value  <= res.value;
      out_last   <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

// File: test/testbench.sv
// Self-checking stream testbench for the ordered list insert/delete/dump block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import oli_pkg::*;

  // Mode code that the block ignores
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT    = 60;
  localparam int PHASE_ITEMS = 38;
  localparam int NUM_ROWS    = 21;

  // One directed stimulus row; typed rows carry their single expected word
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        typed;
    logic [2:0]  st;
    logic [31:0] res_val;
  } stim_row_t;

  // One result word as it leaves the block
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic        last;
  } list_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = MODE_INSERT;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [31:0] list_model[$];
  list_word_t  due_results[$];
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     32'h0000_0000},
    '{MODE_DELETE, 32'h8000_0000, 5'd1,  1'b1, ST_EMPTY,     32'h8000_0000},
    '{MODE_NONE,   32'h1234_5678, 5'd1,  1'b0, ST_INSERTED,  32'h0000_0000},
    '{MODE_INSERT, 32'h8000_0000, 5'd1,  1'b1, ST_INSERTED,  32'h8000_0000},
    '{MODE_INSERT, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_INSERTED,  32'h7FFF_FFFF},
    '{MODE_INSERT, 32'h0000_0000, 5'd1,  1'b1, ST_INSERTED,  32'h0000_0000},
    '{MODE_INSERT, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_INSERTED,  32'hFFFF_FFFF},
    '{MODE_INSERT, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_INSERTED,  32'h7FFF_FFFF},
    '{MODE_DELETE, 32'h0000_0001, 5'd1,  1'b1, ST_NOT_FOUND, 32'h0000_0001},
    '{MODE_DELETE, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_DELETED,   32'h7FFF_FFFF},
    '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_DUMPED,    32'h0000_0000},
    '{MODE_DELETE, 32'h0000_0000, 5'd1,  1'b1, ST_DELETED,   32'h0000_0000},
    '{MODE_INSERT, 32'h0000_0100, 5'd13, 1'b1, ST_INSERTED,  32'h0000_0100},
    '{MODE_INSERT, 32'h5A5A_5A5A, 5'd1,  1'b1, ST_FULL,      32'h5A5A_5A5A},
    '{MODE_DUMP,   32'hFFFF_FFFF, 5'd1,  1'b0, ST_DUMPED,    32'h0000_0000},
    '{MODE_DELETE, 32'h0000_010C, 5'd1,  1'b1, ST_DELETED,   32'h0000_010C},
    '{MODE_DELETE, 32'h8000_0000, 5'd1,  1'b1, ST_DELETED,   32'h8000_0000},
    '{MODE_INSERT, 32'hA5A5_A5A5, 5'd1,  1'b1, ST_INSERTED,  32'hA5A5_A5A5},
    '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_DUMPED,    32'h0000_0000},
    '{MODE_NONE,   32'hFFFF_FFFF, 5'd1,  1'b0, ST_INSERTED,  32'h0000_0000},
    '{MODE_DUMP,   32'h0000_0000, 5'd1,  1'b0, ST_DUMPED,    32'h0000_0000}
  };

  ordered_list_insert_delete uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one request to the list model and queue the words it must produce
  task automatic list_step(input logic [1:0] mode, input logic [31:0] value);
    int hit;
    hit = -1;
    case (mode)
      MODE_INSERT: begin
        if (list_model.size() >= CAPACITY) begin
          due_results.push_back('{ST_FULL, value, 1'b1});
        end else begin
          list_model.push_back(value);
          due_results.push_back('{ST_INSERTED, value, 1'b1});
        end
      end
      MODE_DELETE: begin
        if (list_model.size() == 0) begin
          due_results.push_back('{ST_EMPTY, value, 1'b1});
        end else begin
          // Find the first match from the head
          for (int i = 0; i < list_model.size(); i++) begin
            if (hit < 0 && list_model[i] == value) hit = i;
          end
          if (hit >= 0) begin
            list_model.delete(hit);
            due_results.push_back('{ST_DELETED, value, 1'b1});
          end else begin
            due_results.push_back('{ST_NOT_FOUND, value, 1'b1});
          end
        end
      end
      MODE_DUMP: begin
        if (list_model.size() == 0) begin
          due_results.push_back('{ST_EMPTY, 32'h0, 1'b1});
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            due_results.push_back('{ST_DUMPED, list_model[i], i == list_model.size() - 1});
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one request word, with random idle gaps ahead of it
  task automatic send_word(input logic [1:0] mode, input logic [31:0] value,
                           input logic typed, input logic [2:0] st,
                           input logic [31:0] res_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    list_step(mode, value);
    if (typed) due_results[due_results.size() - 1] = '{st, res_val, 1'b1};
  endtask

  // Build one random request; the list grows and shrinks in alternate stretches
  task automatic random_item(input int n);
    int unsigned r;
    bit          grow;
    logic [1:0]  mode;
    logic [31:0] value;
    r    = $urandom_range(0, 99);
    grow = ((n / 30) % 2) == 0;
    if (r < 5) mode = MODE_NONE;
    else if (r < 15) mode = MODE_DUMP;
    else if (r < (grow ? 70 : 40)) mode = MODE_INSERT;
    else mode = MODE_DELETE;
    r = $urandom_range(0, 99);
    if (mode == MODE_DELETE && list_model.size() != 0 && r < 70) begin
      value = list_model[$urandom_range(0, list_model.size() - 1)];
    end else if (r < 50) begin
      value = $urandom;
    end else if (r < 80) begin
      // Few distinct values, so duplicates are common
      value = 32'($urandom_range(0, 3)) - 32'd2;
    end else begin
      value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    send_word(mode, value, 1'b0, ST_INSERTED, 32'h0);
  endtask

  // Check each result word against the oldest expectation; drive tready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word status=%0d value=%h last=%b", $realtime,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        if (m_axis_tuser !== due_results[0].status ||
            m_axis_tdata !== due_results[0].value ||
            m_axis_tlast !== due_results[0].last) begin
          err_count++;
          $display("%0t: mismatch expected status=%0d value=%h last=%b,",
                   $realtime, due_results[0].status, due_results[0].value,
                   due_results[0].last,
                   " got status=%0d value=%h last=%b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
        void'(due_results.pop_front());
      end
    end
    // Take a requested hold-off and count it down here
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_word(directed_rows[i].mode, directed_rows[i].value + 32'(k),
                  directed_rows[i].typed, directed_rows[i].st,
                  directed_rows[i].res_val + 32'(k));
      end
    end

    // Random requests under each idling pattern, then a long receiver hold-off
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req = HOLD_CYCLES;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(p * PHASE_ITEMS + n);
    end
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;

    // Drain, then give stray words a chance to show up
    while (due_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
